// ----- src/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// shared types and constants of the key state tracker with typematic repeat
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int unsigned NUM_KEYS_DEF = 256;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned STEP_W  = 20;
  localparam int unsigned FLAG_W  = 3;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DELAY_W = 22;
  localparam int unsigned TIMER_W = 24;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned CFG_DW  = 22;
  localparam int unsigned GRP_N   = 3;

  // flag bits of one entry
  localparam logic [FLAG_W-1:0] FLG_PRESSED  = 3'b001;
  localparam logic [FLAG_W-1:0] FLG_DOWN     = 3'b010;
  localparam logic [FLAG_W-1:0] FLG_RELEASED = 3'b100;

  // register reset values, 0.4 s and 1/15 s in microseconds
  localparam logic [DELAY_W-1:0]        DELAY_RST    = 22'd400000;
  localparam logic [DELAY_W-1:0]        INTERVAL_RST = 22'd66667;
  localparam logic signed [TIMER_W-1:0] TIMER_RST    = 24'sd400000;

  // group code ranges
  localparam logic [CODE_W-1:0] ANY_LO_END   = 8'hb8;
  localparam logic [CODE_W-1:0] ANY_HI_START = 8'hde;
  localparam logic [CODE_W-1:0] KEY_LO_END   = 8'ha6;
  localparam logic [CODE_W-1:0] KEY_MID_LO   = 8'hb0;
  localparam logic [CODE_W-1:0] KEY_HI_START = 8'he0;
  localparam logic [CODE_W-1:0] MOUSE_LO     = 8'ha6;
  localparam logic [CODE_W-1:0] MOUSE_HI     = 8'hae;

  localparam int unsigned GRP_ANY   = 0;
  localparam int unsigned GRP_KEY   = 1;
  localparam int unsigned GRP_MOUSE = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_REL_ALL = 3'd4
  } kst_cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_REP_EN       = 2'd0,
    CFG_REP_DELAY    = 2'd1,
    CFG_REP_INTERVAL = 2'd2
  } kst_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_KEY_RD,
    ST_KEY_UPD,
    ST_OUT
  } kst_state_e;

  typedef struct packed {
    logic [FLAG_W-1:0]        flags;
    logic signed [TIMER_W-1:0] timer;
  } kst_entry_t;

endpackage

`default_nettype wire

// ----- src/key_state_tracker_with_repeat.sv -----
// ----------------------------------------------------------------------------
// key_state_tracker_with_repeat
// key and group flag table with typematic repeat timers
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid_i / in_stall_o) carries one command per transfer:
//    press, release, tick, query or release all, with key code and time step
//  - output channel (out_valid_o / out_stall_i) returns one result per command:
//    flags of the key, flags and last codes of the three groups after update
//  - press, release and query go from one transfer to the next through key read,
//    update, output register load and return to idle
//  - tick and release all walk every entry through one shared update unit,
//    one entry per cycle, the group entries first and then the keys from the
//    key memory port, before the key read, update and output load steps
//  - the block takes one command at a time; in_stall_o is high while it works
//  - a result waiting under out_stall_i does not hold up the next command; it
//    only holds the final output load of the following one
//  - reset clears the key table at once through one valid bit per entry, so
//    there is no clearing pass; registers go to 0, 400000 us and 66667 us
//  - configuration, unchecked by the block, is written by users only while idle
// ----------------------------------------------------------------------------
`default_nettype none

module key_state_tracker_with_repeat #(
  parameter int unsigned NUM_KEYS = kst_pkg::NUM_KEYS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [kst_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  wire logic [kst_pkg::CFG_DW-1:0]   cfg_data_i,
  // command channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [kst_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [kst_pkg::CODE_W-1:0]   key_code_i,
  input  wire logic [kst_pkg::STEP_W-1:0]   time_step_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [kst_pkg::FLAG_W-1:0]        key_flags_o,
  output logic [kst_pkg::FLAG_W-1:0]        any_flags_o,
  output logic [kst_pkg::FLAG_W-1:0]        anykey_flags_o,
  output logic [kst_pkg::FLAG_W-1:0]        anymouse_flags_o,
  output logic [kst_pkg::CODE_W-1:0]        last_any_code_o,
  output logic [kst_pkg::CODE_W-1:0]        last_key_code_o,
  output logic [kst_pkg::CODE_W-1:0]        last_mouse_code_o
);

  import kst_pkg::*;

  localparam int unsigned KAW     = $clog2(NUM_KEYS);
  localparam int unsigned SWEEP_N = NUM_KEYS + GRP_N;   // groups first, then keys
  localparam int unsigned SW      = $clog2(SWEEP_N + 1);

  // sequencer
  kst_state_e state_q, state_d;

  // command held for the whole item
  logic [CMD_W-1:0]          cmd_q;
  logic [CODE_W-1:0]         code_q;
  logic [STEP_W-1:0]         dt_q;
  logic signed [TIMER_W-1:0] ivd_q;    // interval minus time step

  // configuration
  logic               rep_en_q;
  logic [DELAY_W-1:0] delay_q;
  logic [DELAY_W-1:0] interval_q;

  // sweep counter and update stage
  logic [SW-1:0] sw_q;
  logic          st_v_q;
  logic [SW-1:0] st_idx_q;

  // key table
  kst_entry_t              mem_q [NUM_KEYS];
  kst_entry_t              mem_rd_q;
  logic [NUM_KEYS-1:0]     vld_q;
  logic                    vld_rd_q;
  logic                    mem_we;
  logic [KAW-1:0]          mem_wa;
  logic [KAW-1:0]          mem_ra;
  kst_entry_t              mem_wd;

  // group entries
  logic [FLAG_W-1:0]         grp_st_q   [GRP_N];
  logic signed [TIMER_W-1:0] grp_tm_q   [GRP_N];
  logic [CODE_W-1:0]         grp_last_q [GRP_N];

  logic [FLAG_W-1:0] key_flags_q;

  // output register
  logic              out_valid_q;
  logic [FLAG_W-1:0] out_key_q, out_any_q, out_kbd_q, out_mouse_q;
  logic [CODE_W-1:0] out_lany_q, out_lkbd_q, out_lmouse_q;

  // decoded helpers
  logic                sweep_issue;
  logic                sweep_upd;
  logic                sweep_grp;
  logic                key_present;
  logic                key_event;
  logic                out_free;
  logic [GRP_N-1:0]    in_grp;
  kst_entry_t          key_cur;
  logic [FLAG_W-1:0]   key_new;

  // shared update unit
  kst_entry_t                u_in;
  kst_entry_t                u_out;
  logic signed [TIMER_W-1:0] u_sub;
  logic signed [TIMER_W-1:0] u_add;

  assign key_present = ({1'b0, code_q} < (CODE_W + 1)'(NUM_KEYS));
  assign key_event   = (cmd_q == CMD_PRESS) || (cmd_q == CMD_RELEASE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sweep_issue = (state_q == ST_SWEEP) && (sw_q < SW'(SWEEP_N));
  assign sweep_upd   = (state_q == ST_SWEEP) && st_v_q;
  assign sweep_grp   = st_idx_q < SW'(GRP_N);

  // group membership of the event code
  always_comb begin
    in_grp[GRP_ANY]   = (code_q < ANY_LO_END) || (code_q > ANY_HI_START);
    in_grp[GRP_KEY]   = (code_q < KEY_LO_END)
                        || ((code_q >= KEY_MID_LO) && (code_q < ANY_LO_END))
                        || (code_q >= KEY_HI_START);
    in_grp[GRP_MOUSE] = (code_q >= MOUSE_LO) && (code_q <= MOUSE_HI);
  end

  // entry read back from the table, an unwritten entry reads as its reset value
  always_comb begin
    if (vld_rd_q) begin
      key_cur = mem_rd_q;
    end else begin
      key_cur.flags = '0;
      key_cur.timer = TIMER_RST;
    end
  end

  // flags after a press or release of the key itself
  always_comb begin
    key_new = key_cur.flags;
    if (cmd_q == CMD_PRESS) begin
      key_new = key_cur.flags | FLG_PRESSED | FLG_DOWN;
    end else if (cmd_q == CMD_RELEASE) begin
      key_new = (key_cur.flags | FLG_RELEASED) & ~FLG_DOWN;
    end
  end

  // shared unit: tick or release-all applied to one entry
  always_comb begin
    if (sweep_grp) begin
      u_in.flags = grp_st_q[st_idx_q[1:0]];
      u_in.timer = grp_tm_q[st_idx_q[1:0]];
    end else begin
      u_in = key_cur;
    end
    u_sub = u_in.timer - $signed({{(TIMER_W - STEP_W){1'b0}}, dt_q});
    u_add = u_in.timer + ivd_q;
    u_out = u_in;
    if (cmd_q == CMD_TICK) begin
      u_out.flags = u_in.flags & FLG_DOWN;
      if ((u_out.flags != '0) && rep_en_q) begin
        if (u_in.timer > 0) begin
          if (u_sub <= 0) begin
            // timer ran out: repeat, then add the interval
            u_out.flags = u_out.flags | FLG_PRESSED;
            u_out.timer = u_add;
          end else begin
            u_out.timer = u_sub;
          end
        end
      end else begin
        u_out.timer = $signed({{(TIMER_W - DELAY_W){1'b0}}, delay_q});
      end
    end else if ((u_in.flags & FLG_DOWN) != '0) begin
      u_out.flags = (u_in.flags | FLG_RELEASED) & ~FLG_DOWN;
    end
  end

  // key table port control
  always_comb begin
    if (state_q == ST_SWEEP) begin
      mem_ra = KAW'(sw_q - SW'(GRP_N));
    end else begin
      mem_ra = code_q[KAW-1:0];
    end
    mem_we = 1'b0;
    mem_wa = code_q[KAW-1:0];
    mem_wd = key_cur;
    if (sweep_upd && !sweep_grp) begin
      mem_we = 1'b1;
      mem_wa = KAW'(st_idx_q - SW'(GRP_N));
      mem_wd = u_out;
    end else if ((state_q == ST_KEY_UPD) && key_event && key_present) begin
      mem_we      = 1'b1;
      mem_wd.flags = key_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if ((cmd_i == CMD_TICK) || (cmd_i == CMD_REL_ALL)) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_KEY_RD;
          end
        end
      end
      ST_SWEEP: begin
        if ((sw_q == SW'(SWEEP_N)) && !st_v_q) begin
          state_d = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        state_d = ST_KEY_UPD;
      end
      ST_KEY_UPD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // command capture, sweep control, valid bits, groups, configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_QUERY;
      code_q      <= '0;
      dt_q        <= '0;
      ivd_q       <= '0;
      rep_en_q    <= 1'b0;
      delay_q     <= DELAY_RST;
      interval_q  <= INTERVAL_RST;
      sw_q        <= '0;
      st_v_q      <= 1'b0;
      st_idx_q    <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      key_flags_q <= '0;
      for (int g = 0; g < GRP_N; g++) begin
        grp_st_q[g]   <= '0;
        grp_tm_q[g]   <= TIMER_RST;
        grp_last_q[g] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REP_EN:       rep_en_q   <= cfg_data_i[0];
          CFG_REP_DELAY:    delay_q    <= cfg_data_i;
          CFG_REP_INTERVAL: interval_q <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == ST_IDLE) && in_valid_i) begin
        cmd_q  <= cmd_i;
        code_q <= key_code_i;
        dt_q   <= time_step_i;
        ivd_q  <= $signed({{(TIMER_W - DELAY_W){1'b0}}, interval_q})
                  - $signed({{(TIMER_W - STEP_W){1'b0}}, time_step_i});
        sw_q   <= '0;
      end

      // one entry read per cycle, updated and written back the next
      st_v_q <= sweep_issue;
      if (sweep_issue) begin
        st_idx_q <= sw_q;
        sw_q     <= sw_q + SW'(1);
      end

      vld_rd_q <= vld_q[mem_ra];
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end

      if (sweep_upd && sweep_grp) begin
        grp_st_q[st_idx_q[1:0]] <= u_out.flags;
        grp_tm_q[st_idx_q[1:0]] <= u_out.timer;
      end

      if (state_q == ST_KEY_UPD) begin
        key_flags_q <= key_present ? (key_event ? key_new : key_cur.flags) : '0;
        if (key_event) begin
          for (int g = 0; g < GRP_N; g++) begin
            if (in_grp[g]) begin
              grp_last_q[g] <= code_q;
              if (cmd_q == CMD_PRESS) begin
                grp_st_q[g] <= grp_st_q[g] | FLG_PRESSED | FLG_DOWN;
              end else begin
                grp_st_q[g] <= (grp_st_q[g] | FLG_RELEASED) & ~FLG_DOWN;
              end
            end
          end
        end
      end
    end
  end

  // output register, loaded once the item is done and the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_key_q    <= key_flags_q;
      out_any_q    <= grp_st_q[GRP_ANY];
      out_kbd_q    <= grp_st_q[GRP_KEY];
      out_mouse_q  <= grp_st_q[GRP_MOUSE];
      out_lany_q   <= grp_last_q[GRP_ANY];
      out_lkbd_q   <= grp_last_q[GRP_KEY];
      out_lmouse_q <= grp_last_q[GRP_MOUSE];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_flags_o       = out_key_q;
  assign any_flags_o       = out_any_q;
  assign anykey_flags_o    = out_kbd_q;
  assign anymouse_flags_o  = out_mouse_q;
  assign last_any_code_o   = out_lany_q;
  assign last_key_code_o   = out_lkbd_q;
  assign last_mouse_code_o = out_lmouse_q;

endmodule

`default_nettype wire
